// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; the core module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define KBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define KBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/kbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kbe_pkg;

    localparam int IN_SLOTS      = 6;
    localparam int DEF_KEY_SLOTS = 6;

    localparam logic [7:0] MOD_BASE = 8'he0;
    localparam logic [7:0] MOD_TOP  = 8'he7;

    localparam logic [15:0] RST_REPEAT_DELAY  = 16'd50;
    localparam logic [15:0] RST_REPEAT_PERIOD = 16'd5;
    localparam logic [7:0]  RST_USAGE_MIN     = 8'd4;
    localparam logic [7:0]  RST_USAGE_MAX     = 8'd221;

    typedef enum logic [1:0] {
        CFG_REPEAT_DELAY  = 2'd0,
        CFG_REPEAT_PERIOD = 2'd1,
        CFG_USAGE_MIN     = 2'd2,
        CFG_USAGE_MAX     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] repeat_delay;
        logic [15:0] repeat_period;
        logic [7:0]  usage_min;
        logic [7:0]  usage_max;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  usage;
        logic [15:0] delay_cnt;
        logic [15:0] period_cnt;
    } t_rep_state;

    function automatic logic usage_eligible(input logic [7:0] u, input t_cfg cfg);
        return (u != 8'd0) && (u >= cfg.usage_min) && (u <= cfg.usage_max);
    endfunction

endpackage
`default_nettype wire

// File: rtl/kbe_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// Report/tick evaluation: event list and next repeat state for one transaction.
module kbe_eval #(
    parameter int KEY_SLOTS = kbe_pkg::DEF_KEY_SLOTS
) (
    input  kbe_pkg::t_cfg       i_cfg,
    input  logic                i_mode,
    input  logic [7:0]          i_mods,
    input  logic [7:0]          i_keys      [kbe_pkg::IN_SLOTS],
    input  logic [7:0]          i_prev_mods,
    input  logic [7:0]          i_prev_keys [(KEY_SLOTS < kbe_pkg::IN_SLOTS) ?
                                             KEY_SLOTS : kbe_pkg::IN_SLOTS],
    input  kbe_pkg::t_rep_state i_rep,
    output logic [8 + 2 * ((KEY_SLOTS < kbe_pkg::IN_SLOTS) ?
                  KEY_SLOTS : kbe_pkg::IN_SLOTS):0] o_ev_mask,
    output logic [7:0]          o_ev_usage  [9 + 2 * ((KEY_SLOTS < kbe_pkg::IN_SLOTS) ?
                                             KEY_SLOTS : kbe_pkg::IN_SLOTS)],
    output logic [8 + 2 * ((KEY_SLOTS < kbe_pkg::IN_SLOTS) ?
                  KEY_SLOTS : kbe_pkg::IN_SLOTS):0] o_ev_pressed,
    output kbe_pkg::t_rep_state o_rep
);
    import kbe_pkg::*;

    localparam int USED = (KEY_SLOTS < IN_SLOTS) ? KEY_SLOTS : IN_SLOTS;
    localparam int REL0 = 8;
    localparam int PRS0 = 8 + USED;
    localparam int TICK = 8 + 2 * USED;

    logic [USED-1:0] old_in_new;
    logic [USED-1:0] new_in_old;
    logic [USED-1:0] new_press;
    logic            held_in_new;
    logic            held_in_old;
    logic [7:0]      first_elig;
    logic [7:0]      last_new;
    logic            have_new;
    logic [7:0]      rep_pick;
    logic [15:0]     d_eff;
    logic [15:0]     p_eff;
    logic [15:0]     delay_inc;
    logic [15:0]     period_inc;
    t_rep_state      rep_report;
    t_rep_state      rep_tick;
    logic            tick_fire;

    // slot cross-compare
    always_comb begin
        held_in_new = 1'b0;
        held_in_old = 1'b0;
        for (int i = 0; i < USED; i++) begin
            old_in_new[i] = 1'b0;
            new_in_old[i] = 1'b0;
            for (int j = 0; j < USED; j++) begin
                if (i_keys[j] == i_prev_keys[i]) old_in_new[i] = 1'b1;
                if (i_prev_keys[j] == i_keys[i]) new_in_old[i] = 1'b1;
            end
            new_press[i] = (i_keys[i] != 8'd0) && !new_in_old[i];
            if (i_keys[i] == i_rep.usage)      held_in_new = 1'b1;
            if (i_prev_keys[i] == i_rep.usage) held_in_old = 1'b1;
        end
    end

    // repeat usage choice after a report
    always_comb begin
        first_elig = 8'd0;
        for (int i = USED - 1; i >= 0; i--) begin
            if (usage_eligible(i_keys[i], i_cfg)) first_elig = i_keys[i];
        end
        last_new = 8'd0;
        have_new = 1'b0;
        for (int i = 0; i < USED; i++) begin
            if (new_press[i] && usage_eligible(i_keys[i], i_cfg)) begin
                last_new = i_keys[i];
                have_new = 1'b1;
            end
        end
        if (have_new) begin
            rep_pick = last_new;
        end else if ((i_rep.usage != 8'd0) && held_in_new) begin
            rep_pick = i_rep.usage;
        end else begin
            rep_pick = first_elig;
        end
        if (rep_pick != i_rep.usage) begin
            rep_report = '{usage: rep_pick, delay_cnt: 16'd0, period_cnt: 16'd0};
        end else begin
            rep_report = i_rep;
        end
    end

    // tick: delay phase, then period phase
    always_comb begin
        d_eff      = (i_cfg.repeat_delay  == 16'd0) ? 16'd1 : i_cfg.repeat_delay;
        p_eff      = (i_cfg.repeat_period == 16'd0) ? 16'd1 : i_cfg.repeat_period;
        delay_inc  = i_rep.delay_cnt + 16'd1;
        period_inc = i_rep.period_cnt + 16'd1;
        rep_tick   = i_rep;
        tick_fire  = 1'b0;
        if (i_rep.usage == 8'd0) begin
            rep_tick = i_rep;
        end else if (!held_in_old) begin
            rep_tick = '{usage: 8'd0, delay_cnt: 16'd0, period_cnt: 16'd0};
        end else if (i_rep.delay_cnt < d_eff) begin
            rep_tick.delay_cnt = delay_inc;
            if (delay_inc == d_eff) begin
                rep_tick.period_cnt = 16'd0;
                tick_fire = 1'b1;
            end
        end else if (period_inc >= p_eff) begin
            rep_tick.period_cnt = 16'd0;
            tick_fire = 1'b1;
        end else begin
            rep_tick.period_cnt = period_inc;
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            o_ev_mask[b]    = !i_mode && (i_prev_mods[b] != i_mods[b]);
            o_ev_usage[b]   = (MOD_BASE + 8'(b)) & MOD_TOP;
            o_ev_pressed[b] = i_mods[b];
        end
        for (int i = 0; i < USED; i++) begin
            o_ev_mask[REL0 + i]    = !i_mode && (i_prev_keys[i] != 8'd0) && !old_in_new[i];
            o_ev_usage[REL0 + i]   = i_prev_keys[i];
            o_ev_pressed[REL0 + i] = 1'b0;
            o_ev_mask[PRS0 + i]    = !i_mode && new_press[i];
            o_ev_usage[PRS0 + i]   = i_keys[i];
            o_ev_pressed[PRS0 + i] = 1'b1;
        end
        o_ev_mask[TICK]    = i_mode && tick_fire;
        o_ev_usage[TICK]   = i_rep.usage;
        o_ev_pressed[TICK] = 1'b1;
        o_rep = i_mode ? rep_tick : rep_report;
    end

endmodule
`default_nettype wire

// File: rtl/keyboard_report_key_events_core.sv
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+------------------------------------
// in      | input     | i_in_valid / o_in_ready    | i_mode, i_modifiers, i_key_slot_0..5
// out     | output    | o_out_valid / i_out_ready  | o_event_usage, o_event_pressed,
//         |           |                            | o_event_last
// cfg     | input     | i_cfg_we (no handshake)    | i_cfg_index, i_cfg_wdata
//
// A transaction is evaluated as it is accepted and its events land in a job register;
// the job register feeds the output register one event per cycle while the output is not stalled.
// The next input is accepted in the cycle its predecessor's last event moves into the
// output register.
// Output stalls hold the job register and, once it is down to one event, o_in_ready.
// Reset (synchronous, active low) restores register defaults and clears key/repeat state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module keyboard_report_key_events_core #(
    parameter int KEY_SLOTS = kbe_pkg::DEF_KEY_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_modifiers,
    input  logic [7:0]  i_key_slot_0,
    input  logic [7:0]  i_key_slot_1,
    input  logic [7:0]  i_key_slot_2,
    input  logic [7:0]  i_key_slot_3,
    input  logic [7:0]  i_key_slot_4,
    input  logic [7:0]  i_key_slot_5,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_event_usage,
    output logic        o_event_pressed,
    output logic        o_event_last
);
    import kbe_pkg::*;

    localparam int USED = (KEY_SLOTS < IN_SLOTS) ? KEY_SLOTS : IN_SLOTS;
    localparam int NEV  = 9 + 2 * USED;

    t_cfg            r_cfg;
    logic [7:0]      r_prev_mods;
    logic [7:0]      r_prev_keys [USED];
    t_rep_state      r_rep;
    logic [NEV-1:0]  r_job_mask;
    logic [7:0]      r_job_usage [NEV];
    logic [NEV-1:0]  r_job_pressed;
    logic            r_out_valid;
    logic [7:0]      r_out_usage;
    logic            r_out_pressed;
    logic            r_out_last;

    logic [7:0]      in_keys [IN_SLOTS];
    logic [NEV-1:0]  ev_mask;
    logic [7:0]      ev_usage [NEV];
    logic [NEV-1:0]  ev_pressed;
    t_rep_state      n_rep;

    logic            in_take;
    logic            out_load;
    logic            job_single;
    logic [NEV-1:0]  pick;
    logic [NEV-1:0]  job_rest;
    logic [7:0]      pick_usage;
    logic            pick_pressed;

    assign in_keys[0] = i_key_slot_0;
    assign in_keys[1] = i_key_slot_1;
    assign in_keys[2] = i_key_slot_2;
    assign in_keys[3] = i_key_slot_3;
    assign in_keys[4] = i_key_slot_4;
    assign in_keys[5] = i_key_slot_5;

    kbe_eval #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_eval (
        .i_cfg        (r_cfg),
        .i_mode       (i_mode),
        .i_mods       (i_modifiers),
        .i_keys       (in_keys),
        .i_prev_mods  (r_prev_mods),
        .i_prev_keys  (r_prev_keys),
        .i_rep        (r_rep),
        .o_ev_mask    (ev_mask),
        .o_ev_usage   (ev_usage),
        .o_ev_pressed (ev_pressed),
        .o_rep        (n_rep)
    );

    // lowest pending event goes out first
    always_comb begin
        pick         = r_job_mask & (~r_job_mask + NEV'(1));
        job_rest     = r_job_mask & ~pick;
        job_single   = (job_rest == '0);
        pick_usage   = 8'd0;
        pick_pressed = 1'b0;
        for (int k = 0; k < NEV; k++) begin
            pick_usage   = pick_usage | (r_job_usage[k] & {8{pick[k]}});
            pick_pressed = pick_pressed | (r_job_pressed[k] & pick[k]);
        end
        out_load   = (r_job_mask != '0) && (!r_out_valid || i_out_ready);
        o_in_ready = (r_job_mask == '0) || (job_single && out_load);
        in_take    = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{repeat_delay: RST_REPEAT_DELAY, repeat_period: RST_REPEAT_PERIOD,
                       usage_min: RST_USAGE_MIN, usage_max: RST_USAGE_MAX};
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REPEAT_DELAY:  r_cfg.repeat_delay  <= i_cfg_wdata;
                CFG_REPEAT_PERIOD: r_cfg.repeat_period <= i_cfg_wdata;
                CFG_USAGE_MIN:     r_cfg.usage_min     <= i_cfg_wdata[7:0];
                CFG_USAGE_MAX:     r_cfg.usage_max     <= i_cfg_wdata[7:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= 8'd0;
            for (int i = 0; i < USED; i++) r_prev_keys[i] <= 8'd0;
            r_rep       <= '0;
            r_job_mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_rep      <= n_rep;
                r_job_mask <= ev_mask;
                if (!i_mode) begin
                    r_prev_mods <= i_modifiers;
                    for (int i = 0; i < USED; i++) r_prev_keys[i] <= in_keys[i];
                end
            end else if (out_load) begin
                r_job_mask <= job_rest;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_job_usage   <= ev_usage;
            r_job_pressed <= ev_pressed;
        end
        if (out_load) begin
            r_out_usage   <= pick_usage;
            r_out_pressed <= pick_pressed;
            r_out_last    <= job_single;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_usage   = r_out_usage;
    assign o_event_pressed = r_out_pressed;
    assign o_event_last    = r_out_last;

    `KBE_ASSERT(a_ready_one_left, i_clk, i_rst_n, o_in_ready |-> job_single, "ready with events queued")
    `KBE_ASSERT(a_more_pending, i_clk, i_rst_n, (r_out_valid && !r_out_last) |-> (r_job_mask != '0), "non-last event without rest")
    `KBE_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (!r_out_valid && (r_job_mask == '0)), "reset left events")

endmodule
`default_nettype wire
